[design/psl_pkg.sv]
// Shared types and constants for the PID speed loop with PWM drive mapping.
// No dependencies; used by the channel interface instances and the top level.
`default_nettype none

package psl_pkg;

    // Fixed-point scaling
    localparam int Q12_SHIFT = 12;
    localparam int Q8_SHIFT  = 8;

    // Integral clamp: +/-400.0 in Q10.12
    localparam int INT_LIMIT_UNITS = 400;
    localparam logic signed [22:0] INT_LIMIT = 23'(INT_LIMIT_UNITS * (1 << Q12_SHIFT));

    // 100 percent in Q8.8, and the top timer compare value
    localparam int PERCENT_FULL = 100;
    localparam int PWM_SCALE    = 10;
    localparam logic signed [17:0] FULL_Q8     = 18'(PERCENT_FULL * (1 << Q8_SHIFT));
    localparam logic        [13:0] COMPARE_MAX = 14'(PWM_SCALE * PERCENT_FULL);

    // Register reset values
    localparam logic signed [15:0] OUT_UPPER_RST = 16'sd25600;
    localparam logic signed [15:0] OUT_LOWER_RST = -16'sd25600;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_OUT_UPPER  = 3'd3,
        REG_OUT_LOWER  = 3'd4,
        REG_DRIVE_SIDE = 3'd5
    } t_reg_index;

    // Drive side codes; the fourth code means no drive
    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef struct packed {
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pid_output;
        logic        [9:0]  pwm_compare;
        logic               direction_level;
        logic               pwm_written;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [23:0] value;
    } t_cfg_write;

endpackage

`default_nettype wire

[design/psl_chan_if.sv]
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; the block uses the structs from psl_pkg.
`default_nettype none

interface psl_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/pid_speed_loop_pwm_drive_top.sv]
// PID speed loop with PWM drive mapping: five-stage pipeline, one item per cycle while the output is not held.
// Depends on psl_pkg (types, constants) and psl_chan_if (item channels).
`default_nettype none

// A user's overview: every item on i_in (target and measured speed, Q4.12)
// yields exactly one item on o_out, after passing through every stage listed
// below. A new item is taken in every cycle in which the output is not held;
// the rate is then one item per clock, set by the single pass through the
// pipeline. Stages:
// input register, error/integral (this is where the controller state moves),
// the three gain multiplies, sum with output clamps, and the PWM mapping into
// the output register. All stages advance together, so a held output stalls
// the whole pipe and input ready follows output ready combinationally.
// Configuration writes on i_cfg are always taken (ready is tied high); write
// them only while no item is in flight.
module pid_speed_loop_pwm_drive_top
    import psl_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    psl_chan_if.sink   i_cfg,
    psl_chan_if.sink   i_in,
    psl_chan_if.source o_out
);

    // ---------------- configuration registers ----------------
    logic signed [23:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [15:0] r_out_upper, r_out_lower;
    logic        [1:0]  r_drive_side;
    t_cfg_write         w_cfg;

    assign i_cfg.ready = 1'b1;
    assign w_cfg       = i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_out_upper  <= OUT_UPPER_RST;
            r_out_lower  <= OUT_LOWER_RST;
            r_drive_side <= SIDE_NONE;
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                REG_GAIN_P:     r_gain_p     <= w_cfg.value;
                REG_GAIN_I:     r_gain_i     <= w_cfg.value;
                REG_GAIN_D:     r_gain_d     <= w_cfg.value;
                REG_OUT_UPPER:  r_out_upper  <= w_cfg.value[15:0];
                REG_OUT_LOWER:  r_out_lower  <= w_cfg.value[15:0];
                REG_DRIVE_SIDE: r_drive_side <= w_cfg.value[1:0];
                default: ; // indexes past the list are ignored
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Stage valids: input, error, products, clamped output, result.
    logic r_v_in, r_v_err, r_v_prod, r_v_pid, r_v_out;
    logic w_adv;

    assign w_adv      = !r_v_out || o_out.ready;
    assign i_in.ready = w_adv;
    assign o_out.valid = r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_err  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_pid  <= 1'b0;
            r_v_out  <= 1'b0;
        end else if (w_adv) begin
            r_v_in   <= i_in.valid;
            r_v_err  <= r_v_in;
            r_v_prod <= r_v_err;
            r_v_pid  <= r_v_prod;
            r_v_out  <= r_v_pid;
        end
    end

    // ---------------- stage 1: input register ----------------
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= i_in.data;
        end
    end

    // ---------------- stage 2: error, delta, integral ----------------
    logic signed [21:0] r_integral;   // controller state, Q10.12
    logic signed [15:0] r_prev_err;   // controller state, Q4.12

    logic signed [16:0] w_diff;
    logic signed [15:0] w_err;
    logic signed [22:0] w_int_sum;
    logic signed [21:0] n_integral;
    logic signed [16:0] w_delta;

    assign w_diff = 17'(r_in.target_speed) - 17'(r_in.measured_speed);

    // Saturate the error to 16 bits
    always_comb begin
        if (w_diff[16] != w_diff[15]) begin
            w_err = w_diff[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            w_err = w_diff[15:0];
        end
    end

    assign w_int_sum = 23'(r_integral) + 23'(w_err);

    always_comb begin
        if (w_int_sum > INT_LIMIT) begin
            n_integral = INT_LIMIT[21:0];
        end else if (w_int_sum < -INT_LIMIT) begin
            n_integral = 22'(-INT_LIMIT);
        end else begin
            n_integral = w_int_sum[21:0];
        end
    end

    assign w_delta = 17'(w_err) - 17'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (w_adv && r_v_in) begin
            r_integral <= n_integral;
            r_prev_err <= w_err;
        end
    end

    logic signed [15:0] r_err;
    logic signed [16:0] r_delta;
    logic signed [21:0] r_int_used;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_err      <= w_err;
            r_delta    <= w_delta;
            r_int_used <= n_integral;
        end
    end

    // ---------------- stage 3: gain products, floored to Q8.8 ----------------
    logic signed [39:0] w_p_full;
    logic signed [45:0] w_i_full;
    logic signed [40:0] w_d_full;
    logic signed [27:0] r_p_term;
    logic signed [33:0] r_i_term;
    logic signed [28:0] r_d_term;

    assign w_p_full = 40'(r_gain_p) * 40'(r_err);
    assign w_i_full = 46'(r_gain_i) * 46'(r_int_used);
    assign w_d_full = 41'(r_gain_d) * 41'(r_delta);

    // Dropping the low 12 bits of a two's complement value is a floor
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_term <= w_p_full[39:Q12_SHIFT];
            r_i_term <= w_i_full[45:Q12_SHIFT];
            r_d_term <= w_d_full[40:Q12_SHIFT];
        end
    end

    // ---------------- stage 4: sum and output clamps ----------------
    logic signed [35:0] w_sum;
    logic signed [15:0] n_pid;
    logic signed [15:0] r_pid;

    assign w_sum = 36'(r_p_term) + 36'(r_i_term) + 36'(r_d_term);

    // Upper clamp tested first, so when the clamps cross, a sum above the upper clamp takes the upper value.
    // Whatever survives lies between the 16-bit clamp values.
    always_comb begin
        if (w_sum > 36'(r_out_upper)) begin
            n_pid = r_out_upper;
        end else if (w_sum < 36'(r_out_lower)) begin
            n_pid = r_out_lower;
        end else begin
            n_pid = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pid <= n_pid;
        end
    end

    // ---------------- stage 5: PWM mapping into result register ----------------
    logic signed [17:0] w_pid_ext;
    logic signed [17:0] w_q;          // Q8.8 percent to be scaled
    logic signed [21:0] w_x10;
    logic        [13:0] w_scaled;
    logic        [9:0]  w_compare;
    logic               w_level;
    logic               w_written;
    t_out_item          r_out;

    assign w_pid_ext = 18'(r_pid);

    always_comb begin
        w_q       = '0;
        w_level   = 1'b0;
        w_written = 1'b0;
        unique case (r_drive_side)
            SIDE_LEFT: begin
                w_written = 1'b1;
                if (r_pid[15]) begin
                    w_q     = -w_pid_ext;
                    w_level = 1'b0;
                end else begin
                    w_q     = FULL_Q8 - w_pid_ext;
                    w_level = 1'b1;
                end
            end
            SIDE_RIGHT: begin
                w_written = 1'b1;
                if (r_pid[15]) begin
                    w_q     = FULL_Q8 + w_pid_ext;
                    w_level = 1'b1;
                end else begin
                    w_q     = w_pid_ext;
                    w_level = 1'b0;
                end
            end
            default: ; // no drive, and the unused side code
        endcase
    end

    // 10*q as shift-add; /256 is a shift since q is positive when used
    assign w_x10    = (22'(w_q) <<< 3) + (22'(w_q) <<< 1);
    assign w_scaled = w_x10[21:Q8_SHIFT];

    always_comb begin
        if (w_q <= 18'sd0) begin
            w_compare = '0;
        end else if (w_scaled > COMPARE_MAX) begin
            w_compare = COMPARE_MAX[9:0];
        end else begin
            w_compare = w_scaled[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.pid_output      <= r_pid;
            r_out.pwm_compare     <= w_compare;
            r_out.direction_level <= w_level;
            r_out.pwm_written     <= w_written;
        end
    end

    assign o_out.data = r_out;

endmodule

`default_nettype wire
